@@ src/mdt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mdt_pkg
// Shared types for the maximum drawdown tracker and its fraction divider.
// ----------------------------------------------------------------------------
package mdt_pkg;

  typedef struct packed {
    logic busy;
    logic done;
  } mdt_div_stat_t;

endpackage : mdt_pkg
`default_nettype wire

@@ src/mdt_divider.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mdt_divider
// Restoring divider, one quotient bit per cycle: floor((num << FB) / den),
// for num < den.
// ----------------------------------------------------------------------------
module mdt_divider
  import mdt_pkg::*;
#(
  parameter int MAG_BITS      = 31,
  parameter int FRACTION_BITS = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  input  wire logic [MAG_BITS-1:0]      num,
  input  wire logic [MAG_BITS-1:0]      den,
  output mdt_div_stat_t                 stat,
  output logic      [FRACTION_BITS-1:0] quo
);

  localparam int CNT_W = $clog2(FRACTION_BITS + 1);

  logic [CNT_W-1:0]    cnt;
  logic [MAG_BITS-1:0] rem;
  logic [MAG_BITS-1:0] den_r;
  logic                done;

  logic [MAG_BITS:0]   rem_shl;
  logic [MAG_BITS+1:0] diff;
  logic                ge;
  logic [MAG_BITS-1:0] rem_next;

  always_comb begin
    rem_shl  = {rem, 1'b0};
    diff     = {1'b0, rem_shl} - {2'b00, den_r};
    ge       = ~diff[MAG_BITS+1];
    rem_next = ge ? diff[MAG_BITS-1:0] : rem_shl[MAG_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt   <= CNT_W'(FRACTION_BITS);
        rem   <= num;
        den_r <= den;
        quo   <= '0;
      end else if (cnt != '0) begin
        rem <= rem_next;
        quo <= {quo[FRACTION_BITS-2:0], ge};
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = (cnt != '0);
  assign stat.done = done;

endmodule : mdt_divider
`default_nettype wire

@@ src/max_drawdown_tracker_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// max_drawdown_tracker_top
// Tracks the running peak of valid prices and the largest drawdown fraction
// of a series; emits it on the series' last item and clears.
// Result path: a last item that is skipped or a new peak passes through ST_EMIT to
// the output register; one below the peak first waits in ST_DIV for the divider.
// Input: s_tready is high only in ST_IDLE, so a new item is not taken while a
// division runs, nor after a last item until ST_EMIT has loaded the output, which
// waits while the previous output item is held.
// Reset: synchronous; clears peak, best drawdown and the valid-seen flag.
// ----------------------------------------------------------------------------
module max_drawdown_tracker_top
  import mdt_pkg::*;
#(
  parameter int PRICE_BITS    = 32,
  parameter int FRACTION_BITS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [((PRICE_BITS+7)/8)*8-1:0]   s_tdata,  // price
  input  wire logic                              s_tuser,  // price_is_nan
  input  wire logic                              s_tlast,  // series_end
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic [((FRACTION_BITS+7)/8)*8-1:0]     m_tdata,  // max_drawdown
  output logic                                   m_tuser   // no_valid_price
);

  localparam int MAG_BITS = PRICE_BITS - 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } state_t;

  state_t                   state;
  logic [MAG_BITS-1:0]      peak_price;
  logic [FRACTION_BITS-1:0] best_drawdown;
  logic                     seen_valid;
  logic                     last_pend;
  logic [FRACTION_BITS-1:0] out_dd;

  logic [PRICE_BITS-1:0]    price;
  logic [MAG_BITS-1:0]      mag;
  logic                     in_fire;
  logic                     price_ok;
  logic                     new_peak;
  logic                     below_peak;
  logic                     div_start;
  logic                     out_free;

  mdt_div_stat_t            div_stat;
  logic [FRACTION_BITS-1:0] div_quo;

  always_comb begin
    price      = s_tdata[PRICE_BITS-1:0];
    mag        = price[MAG_BITS-1:0];
    in_fire    = s_tvalid && s_tready;
    price_ok   = !s_tuser && !price[PRICE_BITS-1] && (mag != '0);
    new_peak   = price_ok && (!seen_valid || mag > peak_price);
    below_peak = price_ok && seen_valid && (mag < peak_price);
    div_start  = in_fire && below_peak;
    out_free   = !m_tvalid || m_tready;
  end

  assign s_tready = (state == ST_IDLE);

  mdt_divider #(
    .MAG_BITS      (MAG_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (peak_price - mag),
    .den   (peak_price),
    .stat  (div_stat),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      peak_price    <= '0;
      best_drawdown <= '0;
      seen_valid    <= 1'b0;
      last_pend     <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      if (state == ST_EMIT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            last_pend <= s_tlast;
            if (new_peak) begin
              peak_price <= mag;
              seen_valid <= 1'b1;
            end
            if (below_peak) begin
              state <= ST_DIV;
            end else if (s_tlast) begin
              state <= ST_EMIT;
            end
          end
        end
        ST_DIV: begin
          if (div_stat.done) begin
            if (div_quo > best_drawdown) begin
              best_drawdown <= div_quo;
            end
            state <= last_pend ? ST_EMIT : ST_IDLE;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_dd        <= seen_valid ? best_drawdown : '0;
            m_tuser       <= !seen_valid;
            peak_price    <= '0;
            best_drawdown <= '0;
            seen_valid    <= 1'b0;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    m_tdata                  = '0;
    m_tdata[FRACTION_BITS-1:0] = out_dd;
  end

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> state == ST_DIV)
    else $error("divider finished outside the divide state");

  a_div_busy: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> div_stat.busy || div_stat.done)
    else $error("divide state without an active divider");

  a_div_peak: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> seen_valid && peak_price != '0)
    else $error("divide started without a valid peak");

  a_clear_idle: assert property (@(posedge clk) disable iff (rst)
    !seen_valid |-> peak_price == '0 && best_drawdown == '0)
    else $error("tracker state not clear without a valid price");

  a_emit_clears: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT && out_free |=> m_tvalid && !seen_valid)
    else $error("emit did not load output and clear state");

endmodule : max_drawdown_tracker_top
`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for max_drawdown_tracker_top. Series of price samples
// are streamed in with valid, skipped, not-a-number and out-of-range values;
// an in-bench tracker computes the expected drawdown for each series end and
// every output item is compared in order. Phases vary sender gaps and
// receiver stalls, include a long receiver hold-off and full drains.
// ----------------------------------------------------------------------------
module tb;

  localparam int CLK_HALF       = 4;
  localparam int RESET_CYCLES   = 11;
  localparam int SETTLE_CYCLES  = 40;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 400;

  typedef struct {
    logic [15:0] drawdown;
    logic        none_valid;
  } drawdown_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        m_tuser;

  drawdown_t   drawdown_q[$];
  logic [30:0] trk_peak = '0;
  logic [15:0] trk_best = '0;
  logic        trk_seen = 1'b0;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_request   = 0;
  int hold_left      = 0;
  int errors         = 0;
  int items_sent     = 0;
  int results_seen   = 0;
  int empty_series   = 0;
  int stuck_cycles   = 0;

  max_drawdown_tracker_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #CLK_HALF clk = ~clk;

  function automatic logic [15:0] drop_fraction(logic [30:0] gap, logic [30:0] peak);
    logic [31:0] rem;
    logic [15:0] quo;
    rem = {1'b0, gap};
    quo = '0;
    for (int i = 0; i < 16; i++) begin
      rem = rem << 1;
      quo = quo << 1;
      if (rem >= {1'b0, peak}) begin
        rem    = rem - {1'b0, peak};
        quo[0] = 1'b1;
      end
    end
    return quo;
  endfunction

  task automatic track_sample(logic [31:0] price, logic is_nan, logic last);
    drawdown_t   res;
    logic [15:0] dd;
    if (!is_nan && price != 32'd0 && !price[31]) begin
      if (!trk_seen || price[30:0] > trk_peak) begin
        trk_peak = price[30:0];
        trk_seen = 1'b1;
      end else begin
        dd = drop_fraction(trk_peak - price[30:0], trk_peak);
        if (dd > trk_best) trk_best = dd;
      end
    end
    if (last) begin
      res.drawdown   = trk_seen ? trk_best : 16'd0;
      res.none_valid = !trk_seen;
      drawdown_q.push_back(res);
      trk_peak = '0;
      trk_best = '0;
      trk_seen = 1'b0;
    end
  endtask

  task automatic report_mismatch(string what);
    $display("MISMATCH @%0t: %s", $realtime, what);
    errors++;
  endtask

  task automatic send_item(logic [31:0] price, logic is_nan, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= price;
    s_tuser  <= is_nan;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    track_sample(price, is_nan, last);
    items_sent++;
  endtask

  task automatic drain;
    s_tvalid <= 1'b0;
    while (drawdown_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_price(int unsigned scale_bits, logic [31:0] prev,
                                             logic bad_only);
    int unsigned roll;
    logic [31:0] mask;
    logic [31:0] step;
    logic [31:0] p;
    roll = $urandom_range(99);
    mask = (32'h1 << scale_bits) - 32'h1;
    step = mask >> 4;
    if (bad_only) roll = $urandom_range(7);
    if (roll < 5) begin
      p = $urandom | 32'h8000_0000;
    end else if (roll < 8) begin
      p = 32'd0;
    end else if (roll < 45 && prev != 32'd0) begin
      p = prev + ($urandom & step) - ($urandom & step);
      if (p == 32'd0 || p[31]) p = prev;
    end else begin
      p = $urandom & mask;
    end
    return p;
  endfunction

  task automatic send_series_batch(int n_items, int max_len);
    int          sent;
    int          len;
    int unsigned scale_bits;
    int unsigned roll;
    logic [31:0] prev;
    logic [31:0] p;
    logic        nan;
    logic        bad_only;
    sent = 0;
    while (sent < n_items) begin
      roll = $urandom_range(99);
      if (roll < 70) len = $urandom_range(12, 1);
      else if (roll < 95) len = $urandom_range(40, 13);
      else len = $urandom_range(100, 41);
      if (len > max_len) len = $urandom_range(max_len, 1);
      scale_bits = ($urandom_range(1) != 0) ? 31 : $urandom_range(30, 1);
      bad_only   = ($urandom_range(99) < 5);
      prev       = 32'd0;
      for (int i = 0; i < len; i++) begin
        nan = ($urandom_range(99) < 5);
        p   = nan ? $urandom : pick_price(scale_bits, prev, bad_only);
        if (!nan && p != 32'd0 && !p[31]) prev = p;
        send_item(p, nan, i == len - 1);
        sent++;
      end
    end
  endtask

  task automatic test_directed;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_item(32'd1000, 1'b0, 1'b1);
    send_item(32'h7FFF_FFFF, 1'b1, 1'b0);
    send_item(32'd0, 1'b0, 1'b0);
    send_item(32'h8000_0000, 1'b0, 1'b0);
    send_item(32'hFFFF_FFFF, 1'b0, 1'b1);
    send_item(32'hFFFF_FFFF, 1'b1, 1'b1);
    send_item(32'h7FFF_FFFF, 1'b0, 1'b0);
    send_item(32'd1, 1'b0, 1'b1);
    send_item(32'd2, 1'b0, 1'b0);
    send_item(32'd2, 1'b0, 1'b0);
    send_item(32'd1, 1'b0, 1'b0);
    send_item(32'd100, 1'b0, 1'b0);
    send_item(32'd90, 1'b0, 1'b0);
    send_item(32'd100, 1'b0, 1'b0);
    send_item(32'hAAAA_AAAA, 1'b0, 1'b1);
    send_item(32'd1, 1'b0, 1'b0);
    send_item(32'h5555_5555, 1'b0, 1'b0);
    send_item(32'h2AAA_AAAA, 1'b0, 1'b1);
    send_item(32'h5555_5555, 1'b1, 1'b0);
    send_item(32'h4000_0000, 1'b0, 1'b1);
    drain();
  endtask

  task automatic test_full_rate;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_series_batch(250, 100);
    drain();
  endtask

  task automatic test_sender_gaps;
    send_idle_pct  = 88;
    recv_stall_pct = 0;
    send_series_batch(180, 100);
    drain();
  endtask

  task automatic test_receiver_stalls;
    send_idle_pct  = 0;
    recv_stall_pct = 88;
    send_series_batch(200, 100);
    drain();
  endtask

  task automatic test_mixed_idle;
    send_idle_pct  = 14;
    recv_stall_pct = 14;
    send_series_batch(250, 100);
    drain();
  endtask

  task automatic test_backpressure;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = HOLD_CYCLES;
    send_series_batch(80, 2);
    drain();
  endtask

  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      m_tready <= 1'b0;
      hold_left--;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    drawdown_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (drawdown_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result drawdown=%0d none=%0b",
                                  m_tdata, m_tuser));
      end else begin
        want = drawdown_q.pop_front();
        if (want.none_valid) empty_series++;
        if (m_tdata !== want.drawdown)
          report_mismatch($sformatf("max_drawdown got %0d want %0d",
                                    m_tdata, want.drawdown));
        if (m_tuser !== want.none_valid)
          report_mismatch($sformatf("no_valid_price got %0b want %0b",
                                    m_tuser, want.none_valid));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_full_rate();
    test_sender_gaps();
    test_receiver_stalls();
    test_mixed_idle();
    test_backpressure();
    if (drawdown_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", drawdown_q.size()));
    $display("covered %0d samples over %0d series (%0d with no valid price)",
             items_sent, results_seen, empty_series);
    $display("phases: full rate, sender gaps, receiver stalls, mixed, long hold-off");
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
